// File: src/ols_pkg.sv
// Shared constants and register codes for the octree LOD cell selector.
`default_nettype none

package ols_pkg;

	localparam int ROOT_POW_DEF = 12;   // default log2 of the root cube edge
	localparam int IW           = 16;   // input coordinate width
	localparam int OW           = 17;   // output cube origin width
	localparam int CW           = 20;   // internal coordinate width, fits ROOT_POW up to 16
	localparam int LGW          = 5;    // width of a log2 edge value
	localparam int LODW         = 4;    // lod_step width
	localparam int CPW          = 4;    // cell_pow width
	localparam int QW           = 8;    // quality width
	localparam int THW          = QW + 17;  // distance threshold width
	localparam int AW           = 3;    // APB address width
	localparam int DW           = 32;   // APB data width
	localparam int S_TDATA_W    = 6 * IW;
	localparam int M_TDATA_W    = 64;

	localparam logic [CPW-1:0] CELL_POW_RST = 4'd2;
	localparam logic [QW-1:0]  QUALITY_RST  = 8'd0;

	// register index, taken from paddr[2]
	localparam logic REG_CELL_POW = 1'b0;
	localparam logic REG_QUALITY  = 1'b1;

endpackage

`default_nettype wire

// File: src/octree_lod_cell_select.sv
// Octree LOD cell selector: one pipeline stage per octree level.
//
// channel   dir  handshake               contents
// apb       in   psel/penable/pready     cell_pow (0x0), quality (0x4)
// s_axis    in   s_tvalid/s_tready       player x/y/z, block x/y/z
// m_axis    out  m_tvalid/m_tready       found, lod_step, cube x/y/z, on_grid
//
// One request per cycle while the output is not stalled; the stages are the input register,
// root alignment, root offsets, one stage per octree level and the output register.
// The level chain sets the depth: each level does one subtract, abs and max.
// Reset clears the valid bits and the configuration to its defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module octree_lod_cell_select #(
	parameter int ROOT_POW = ols_pkg::ROOT_POW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ols_pkg::AW-1:0]        paddr,
	input  wire logic [ols_pkg::DW-1:0]        pwdata,
	output logic      [ols_pkg::DW-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// player_x, player_y, player_z, block_x, block_y, block_z (16 bits each)
	input  wire logic [ols_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// found[0], lod_step[4:1], cube_x[21:5], cube_y[38:22], cube_z[55:39],
	// on_grid[56], zero[63:57]
	output logic      [ols_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int N    = ROOT_POW;
	localparam int IW   = ols_pkg::IW;
	localparam int OW   = ols_pkg::OW;
	localparam int CW   = ols_pkg::CW;
	localparam int LGW  = ols_pkg::LGW;
	localparam int LODW = ols_pkg::LODW;
	localparam int QW   = ols_pkg::QW;
	localparam int THW  = ols_pkg::THW;

	localparam logic signed [CW-1:0] ROOT_MASK = ~((CW'(1) << (ROOT_POW - 1)) - CW'(1));
	localparam logic signed [CW-1:0] QUARTER   = CW'(1) << (ROOT_POW - 2);
	localparam logic signed [CW-1:0] ROOT_EDGE = CW'(1) << ROOT_POW;
	localparam logic signed [OW-1:0] OUT_MASK  = ~((OW'(1) << (ROOT_POW - 2)) - OW'(1));

	// configuration
	logic [ols_pkg::CPW-1:0] cell_pow_q;
	logic [QW-1:0]           quality_q;
	logic                    wr_en;
	logic [QW-1:0]           q_eff;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign q_eff  = (quality_q == '0) ? QW'(1) : quality_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_pow_q <= ols_pkg::CELL_POW_RST;
			quality_q  <= ols_pkg::QUALITY_RST;
		end else if (wr_en) begin
			case (paddr[2])
				ols_pkg::REG_CELL_POW: cell_pow_q <= pwdata[ols_pkg::CPW-1:0];
				ols_pkg::REG_QUALITY:  quality_q  <= pwdata[QW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ols_pkg::REG_CELL_POW: prdata = ols_pkg::DW'(cell_pow_q);
			ols_pkg::REG_QUALITY:  prdata = ols_pkg::DW'(quality_q);
			default:               prdata = '0;
		endcase
	end

	// pipeline enable
	logic en;
	logic m_valid_q;
	logic [ols_pkg::M_TDATA_W-1:0] m_data_q;

	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// stage 1: input register
	logic                 v_s1;
	logic signed [IW-1:0] pl_s1 [0:2];
	logic signed [IW-1:0] bk_s1 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s1[i] <= s_tdata[i*IW +: IW];
				bk_s1[i] <= s_tdata[(i+3)*IW +: IW];
			end
		end
	end

	// stage 2: cell alignment of the block, root origin
	logic                 v_s2;
	logic signed [CW-1:0] ab_s2  [0:2];
	logic signed [CW-1:0] org_s2 [0:2];
	logic signed [IW-1:0] pl_s2  [0:2];
	logic signed [IW-1:0] bk_s2  [0:2];
	logic        [CW-1:0] cell_mask;

	assign cell_mask = ~((CW'(1) << cell_pow_q) - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ab_s2[i]  <= CW'(bk_s1[i]) & cell_mask;
				org_s2[i] <= (CW'(pl_s1[i]) & ROOT_MASK) - QUARTER;
				pl_s2[i]  <= pl_s1[i];
				bk_s2[i]  <= bk_s1[i];
			end
		end
	end

	// level chain, index k holds the cube of edge 2^(ROOT_POW-k), or a larger one once the descent stopped
	logic                 lvl_v_s    [0:N];
	logic                 lvl_in_s   [0:N];
	logic                 lvl_done_s [0:N];
	logic [LGW-1:0]       lvl_lg_s   [0:N];
	logic signed [CW-1:0] lvl_org_s  [0:N][0:2];
	logic signed [CW-1:0] lvl_d_s    [0:N][0:2];   // player - origin
	logic signed [CW-1:0] lvl_e_s    [0:N][0:2];   // aligned block - origin
	logic signed [IW-1:0] lvl_bk_s   [0:N][0:2];

	// stage 3: offsets from the root origin and the inside test
	logic signed [CW-1:0] e_root [0:2];
	logic                 inside_root;

	always_comb begin
		inside_root = 1'b1;
		for (int i = 0; i < 3; i++) begin
			e_root[i] = ab_s2[i] - org_s2[i];
			if (e_root[i] < 0 || e_root[i] >= ROOT_EDGE)
				inside_root = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_v_s[0] <= 1'b0;
		end else if (en) begin
			lvl_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvl_in_s[0]   <= inside_root;
			lvl_done_s[0] <= !inside_root;
			lvl_lg_s[0]   <= LGW'(ROOT_POW);
			for (int i = 0; i < 3; i++) begin
				lvl_org_s[0][i] <= org_s2[i];
				lvl_d_s[0][i]   <= CW'(pl_s2[i]) - org_s2[i];
				lvl_e_s[0][i]   <= e_root[i];
				lvl_bk_s[0][i]  <= bk_s2[i];
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_lvl
		localparam int LGC = ROOT_POW - k;
		localparam logic signed [CW-1:0] HALF = CW'(1) << (LGC - 1);

		logic signed [CW-1:0] t   [0:2];
		logic        [CW-1:0] mag [0:2];
		logic        [CW-1:0] cheb;
		logic        [THW-1:0] thr;
		logic                 stop;

		always_comb begin
			cheb = '0;
			for (int i = 0; i < 3; i++) begin
				t[i]   = lvl_d_s[k][i] - HALF;
				mag[i] = t[i][CW-1] ? -t[i] : t[i];
				if (mag[i] > cheb)
					cheb = mag[i];
			end
			// floor(cheb / q) >= edge  is  cheb >= q * edge
			thr  = THW'(q_eff) << LGC;
			stop = lvl_done_s[k] || (LGW'(LGC) <= LGW'(cell_pow_q)) ||
			       (THW'(cheb) >= thr);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lvl_v_s[k+1] <= 1'b0;
			end else if (en) begin
				lvl_v_s[k+1] <= lvl_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lvl_in_s[k+1]   <= lvl_in_s[k];
				lvl_done_s[k+1] <= stop;
				lvl_lg_s[k+1]   <= stop ? lvl_lg_s[k] : lvl_lg_s[k] - LGW'(1);
				for (int i = 0; i < 3; i++) begin
					lvl_bk_s[k+1][i] <= lvl_bk_s[k][i];
					if (!stop && lvl_e_s[k][i] >= HALF) begin
						lvl_org_s[k+1][i] <= lvl_org_s[k][i] + HALF;
						lvl_d_s[k+1][i]   <= lvl_d_s[k][i] - HALF;
						lvl_e_s[k+1][i]   <= lvl_e_s[k][i] - HALF;
					end else begin
						lvl_org_s[k+1][i] <= lvl_org_s[k][i];
						lvl_d_s[k+1][i]   <= lvl_d_s[k][i];
						lvl_e_s[k+1][i]   <= lvl_e_s[k][i];
					end
				end
			end
		end
	end

	// output stage
	logic signed [OW-1:0] cube [0:2];
	logic [LGW-1:0]       lg_diff;
	logic [LODW-1:0]      lod;
	logic                 grid;

	always_comb begin
		lg_diff = lvl_lg_s[N] - LGW'(cell_pow_q);
		lod     = '0;
		if (lvl_in_s[N] && lvl_lg_s[N] > LGW'(cell_pow_q))
			lod = (lg_diff > LGW'(15)) ? LODW'(15) : lg_diff[LODW-1:0];
		grid = 1'b1;
		for (int i = 0; i < 3; i++) begin
			cube[i] = lvl_in_s[N] ? lvl_org_s[N][i][OW-1:0]
			                      : (OW'(lvl_bk_s[N][i]) & OUT_MASK);
			if (cube[i] != OW'(lvl_bk_s[N][i]))
				grid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= lvl_v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= {7'b0, grid, cube[2], cube[1], cube[0], lod, lvl_in_s[N]};
		end
	end

	// checks
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request did not enter the pipeline");

	// only a descent all the way to a unit cube may arrive without a stop
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_v_s[N] && lvl_lg_s[N] != '0 |-> lvl_done_s[N])
		else $error("octree descent not finished at the last level");

	a_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && lvl_v_s[N] |=> m_tvalid)
		else $error("finished item did not reach the output register");

	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == '0)
		else $error("nonzero lod_step on a block outside the root cube");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[4:1]) <= ROOT_POW)
		else $error("lod_step beyond the tree depth");

endmodule

`default_nettype wire

// File: sim/ols_checker.sv
// Checker for the octree LOD cell selector: tracks registers, predicts each request, compares results.
module ols_checker #(
	parameter int ROOT_POW = ols_pkg::ROOT_POW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [ols_pkg::AW-1:0]        paddr,
	input  logic [ols_pkg::DW-1:0]        pwdata,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [ols_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ols_pkg::M_TDATA_W-1:0] m_tdata,
	output int                            mismatches,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW = ols_pkg::IW;
	localparam int OW = ols_pkg::OW;

	// packed so that found sits at bit 0, matching m_tdata
	typedef struct packed {
		logic          on_grid;
		logic [OW-1:0] cube_z;
		logic [OW-1:0] cube_y;
		logic [OW-1:0] cube_x;
		logic [ols_pkg::LODW-1:0] lod_step;
		logic          found;
	} cube_pick_t;

	logic [ols_pkg::CPW-1:0] cell_pow_q;
	logic [ols_pkg::QW-1:0]  quality_q;
	cube_pick_t     expected_picks[$];
	cube_pick_t     want;
	cube_pick_t     got;
	logic [6:0]     pad;
	int             mismatch_cnt;

	function automatic longint align_down(input longint v, input int p);
		return v & ~((longint'(1) << p) - 1);
	endfunction

	function automatic cube_pick_t pick_cube(input logic [ols_pkg::S_TDATA_W-1:0] req,
			input logic [ols_pkg::CPW-1:0] cp, input logic [ols_pkg::QW-1:0] q);
		longint     pl[3];
		longint     bk[3];
		longint     ab[3];
		longint     org[3];
		longint     cube[3];
		longint     edge_len;
		longint     min_edge;
		longint     half_len;
		longint     cheb;
		longint     d;
		int         lg;
		bit         in_root;
		cube_pick_t r;

		edge_len = longint'(1) << ROOT_POW;
		min_edge = longint'(1) << (int'(cp) + 1);
		in_root = 1'b1;
		lg = ROOT_POW;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			pl[i] = longint'($signed(req[IW*i +: IW]));
			bk[i] = longint'($signed(req[IW*(3+i) +: IW]));
			ab[i] = align_down(bk[i], int'(cp));
			org[i] = align_down(pl[i], ROOT_POW - 1) - (longint'(1) << (ROOT_POW - 2));
			if (ab[i] < org[i] || ab[i] >= org[i] + edge_len)
				in_root = 1'b0;
		end
		if (in_root) begin
			while (edge_len >= min_edge) begin
				cheb = 0;
				for (int i = 0; i < 3; i++) begin
					d = pl[i] - org[i] - (edge_len >>> 1);
					if (d < 0)
						d = -d;
					if (d > cheb)
						cheb = d;
				end
				if (q != 0)
					cheb = cheb / longint'(q);
				if (cheb >= edge_len)
					break;
				half_len = edge_len >>> 1;
				for (int i = 0; i < 3; i++)
					if (ab[i] >= org[i] + half_len)
						org[i] += half_len;
				edge_len = half_len;
				lg--;
			end
			if (lg > int'(cp))
				r.lod_step = (lg - int'(cp) > 15) ? 4'd15 : ols_pkg::LODW'(lg - int'(cp));
			for (int i = 0; i < 3; i++)
				cube[i] = org[i];
		end else begin
			for (int i = 0; i < 3; i++)
				cube[i] = align_down(bk[i], ROOT_POW - 2);
		end
		r.found = in_root;
		r.cube_x = OW'(cube[0]);
		r.cube_y = OW'(cube[1]);
		r.cube_z = OW'(cube[2]);
		r.on_grid = (cube[0] == bk[0]) && (cube[1] == bk[1]) && (cube[2] == bk[2]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_pow_q = ols_pkg::CELL_POW_RST;
			quality_q = ols_pkg::QUALITY_RST;
			expected_picks.delete();
			mismatch_cnt = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// retire before accepting, so a same-edge request never meets its own result
			if (m_tvalid && m_tready) begin
				got = cube_pick_t'(m_tdata[56:0]);
				pad = m_tdata[63:57];
				if (expected_picks.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%t: result with no request pending: %h", $realtime, m_tdata);
				end else begin
					want = expected_picks.pop_front();
					if (got.found !== want.found || got.lod_step !== want.lod_step ||
							got.cube_x !== want.cube_x || got.cube_y !== want.cube_y ||
							got.cube_z !== want.cube_z || got.on_grid !== want.on_grid ||
							pad !== '0) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"%t: want found=%0d lod=%0d cube=(%0d,%0d,%0d) grid=%0d,",
								" got found=%0d lod=%0d cube=(%0d,%0d,%0d) grid=%0d pad=%h"},
								$realtime, want.found, want.lod_step, $signed(want.cube_x),
								$signed(want.cube_y), $signed(want.cube_z), want.on_grid,
								got.found, got.lod_step, $signed(got.cube_x),
								$signed(got.cube_y), $signed(got.cube_z), got.on_grid, pad);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_picks.push_back(pick_cube(s_tdata, cell_pow_q, quality_q));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == ols_pkg::REG_CELL_POW)
					cell_pow_q = pwdata[ols_pkg::CPW-1:0];
				else if (paddr[2] == ols_pkg::REG_QUALITY)
					quality_q = pwdata[ols_pkg::QW-1:0];
			end
			mismatches <= mismatch_cnt;
			outstanding <= expected_picks.size();
		end
	end

endmodule

// File: sim/tb.sv
// Testbench top for the octree LOD cell selector: stimulus, flow control and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW  = ols_pkg::IW;
	localparam int DW  = ols_pkg::DW;
	localparam int LAT = ols_pkg::ROOT_POW_DEF + 4;
	localparam int NPH = 10;
	localparam int PH_CP [NPH] = '{0, 8, 12, 15, 5, 1, 3, 2, 7, 4};
	localparam int PH_Q  [NPH] = '{0, 255, 5, 1, 17, 2, 128, 0, 9, 40};
	localparam int PH_N  [NPH] = '{60, 60, 40, 40, 60, 60, 60, 60, 50, 60};

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ols_pkg::AW-1:0]        paddr;
	logic [DW-1:0]                 pwdata;
	logic [DW-1:0]                 prdata;
	logic                          pready;
	logic                          s_tvalid;
	logic                          s_tready;
	// player_x, player_y, player_z, block_x, block_y, block_z (16 bits each)
	logic [ols_pkg::S_TDATA_W-1:0] s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	// found[0], lod_step[4:1], cube_x[21:5], cube_y[38:22], cube_z[55:39],
	// on_grid[56], zero[63:57]
	logic [ols_pkg::M_TDATA_W-1:0] m_tdata;

	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_rx;
	int   pick_errors;
	int   picks_outstanding;

	octree_lod_cell_select u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ols_checker #(.ROOT_POW(ols_pkg::ROOT_POW_DEF)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (pick_errors),
		.outstanding (picks_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("octree_lod_cell_select regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [ols_pkg::S_TDATA_W-1:0] pack_request(input logic [IW-1:0] px,
			input logic [IW-1:0] py, input logic [IW-1:0] pz, input logic [IW-1:0] bx,
			input logic [IW-1:0] by, input logic [IW-1:0] bz);
		return {bz, by, bx, pz, py, px};
	endfunction

	// mostly blocks near the player so the descent goes deep; the rest sit on the player, are scattered or are aligned
	function automatic logic [ols_pkg::S_TDATA_W-1:0] random_request();
		logic [IW-1:0] pl[3];
		logic [IW-1:0] bk[3];
		int            kind;
		int            span;
		int            p;

		kind = $urandom_range(19);
		span = ($urandom_range(3) == 0) ? 64 : 2200;
		p = $urandom_range(11);
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(7))
				0: pl[i] = 16'h8000;
				1: pl[i] = 16'h7FFF;
				2: pl[i] = 16'hFFFF;
				default: pl[i] = IW'($urandom);
			endcase
			if (kind <= 13)
				bk[i] = pl[i] + IW'(int'($urandom_range(2 * span)) - span);
			else if (kind <= 15)
				bk[i] = pl[i];
			else if (kind <= 17)
				bk[i] = IW'($urandom);
			else
				bk[i] = (pl[i] + IW'(int'($urandom_range(4400)) - 2200)) & ~IW'((1 << p) - 1);
		end
		return pack_request(pl[0], pl[1], pl[2], bk[0], bk[1], bk[2]);
	endfunction

	task automatic send_request(input logic [ols_pkg::S_TDATA_W-1:0] req);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_xyz(input int px, input int py, input int pz,
			input int bx, input int by, input int bz);
		send_request(pack_request(IW'(px), IW'(py), IW'(pz), IW'(bx), IW'(by), IW'(bz)));
	endtask

	task automatic write_reg(input logic idx, input logic [DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and let every pending request come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (picks_outstanding != 0);
		repeat (LAT + 4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_rx = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 87;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: cell_pow 2, quality 0
		send_xyz(0, 0, 0, 0, 0, 0);
		send_xyz(0, 0, 0, 1, 1, 1);
		send_xyz(32767, 32767, 32767, 32767, 32767, 32767);
		send_xyz(-32768, -32768, -32768, -32768, -32768, -32768);
		send_xyz(32767, 32767, 32767, -32768, -32768, -32768);
		send_xyz(-32768, -32768, -32768, 32767, 32767, 32767);
		send_xyz(0, 0, 0, -1, -1, -1);
		send_xyz(0, 0, 0, -1024, -1024, -1024);     // low corner of the root cube
		send_xyz(0, 0, 0, 3071, 3071, 3071);        // high corner
		send_xyz(0, 0, 0, 3072, 0, 0);              // just outside, lands on grid
		send_xyz(0, 0, 0, -1025, 0, 0);
		send_xyz(100, -200, 300, 101, -199, 302);
		send_xyz(-5000, 7000, -12345, -3500, 6100, -12325);
		send_xyz(0, 0, 0, 4, 8, 12);
		send_xyz(2047, 2048, -2049, 2050, 2045, -2049);
		send_xyz(21845, 21845, 21845, -21846, -21846, -21846);
		send_xyz(32767, -32768, 0, 29767, -29768, 2000);
		send_xyz(1000, 1000, 1000, 1000, 1000, 5095);

		for (int ph = 0; ph < NPH; ph++) begin
			drain();
			write_reg(ols_pkg::REG_CELL_POW, ($urandom & ~32'hF) | DW'(PH_CP[ph]));
			write_reg(ols_pkg::REG_QUALITY, ($urandom & ~32'hFF) | DW'(PH_Q[ph]));
			if (ph < 4) begin
				send_idle_pct = 26;
				recv_idle_pct <= 87;
			end else if (ph < 7) begin
				send_idle_pct = 87;
				recv_idle_pct <= 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			if (ph == NPH - 1) begin
				// long receiver stall while requests keep coming: pipeline fills up
				fork
					begin
						hold_rx <= 1'b1;
						repeat (120) @(posedge clk);
						hold_rx <= 1'b0;
					end
				join_none
			end
			for (int n = 0; n < PH_N[ph]; n++)
				send_request(random_request());
		end

		drain();
		if (pick_errors == 0 && picks_outstanding == 0)
			$display("octree_lod_cell_select regression: pass");
		else
			$display("octree_lod_cell_select regression: fail");
		$finish;
	end

endmodule
